[rtl/fhlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhlp_pkg
// Shared constants, types and the home-slot hash of the probe table.
// ----------------------------------------------------------------------------
package fhlp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int ENTRY_W     = KEY_W + VAL_W;

    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t HALF_DEPTH = idx_t'(TABLE_DEPTH / 2);
    localparam idx_t LAST_STEP  = idx_t'(TABLE_DEPTH - 1);

    // Result handed from the probe engine to the output register.
    typedef struct packed {
        logic             hit;
        logic             full;
        logic [VAL_W-1:0] value;
        idx_t             slot;
    } result_t;

    // Only the low bits of the product reach the slot index, so only the
    // low bits of key and multiplier take part.
    function automatic idx_t hash_home(input logic [KEY_W-1:0] key);
        logic [2*IDX_W-1:0] prod;
        begin
            prod = key[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
            return prod[IDX_W-1:0];
        end
    endfunction

endpackage

[rtl/fhlp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhlp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fhlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/fhlp_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhlp_engine
// Probe sequencer: walks the slots, keeps valid bits and the entry count,
// and writes new entries on a miss.
// ----------------------------------------------------------------------------
module fhlp_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [fhlp_pkg::KEY_W-1:0] req_key,
    input  logic [fhlp_pkg::VAL_W-1:0] req_value,
    input  logic                     res_free,
    output logic                     res_valid,
    output fhlp_pkg::result_t        res,
    output fhlp_pkg::idx_t           ram_raddr,
    input  logic [fhlp_pkg::ENTRY_W-1:0] ram_rdata,
    output logic                     ram_we,
    output fhlp_pkg::idx_t           ram_waddr,
    output logic [fhlp_pkg::ENTRY_W-1:0] ram_wdata
);
    import fhlp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]             state_reg, state_next;
    idx_t                   idx_reg, idx_next;
    idx_t                   step_reg, step_next;
    idx_t                   count_reg, count_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_W-1:0]       val_reg;

    logic [KEY_W-1:0] slot_key;
    logic [VAL_W-1:0] slot_val;
    logic             slot_valid;
    logic             key_match;

    assign slot_key   = ram_rdata[KEY_W-1:0];
    assign slot_val   = ram_rdata[ENTRY_W-1:KEY_W];
    assign slot_valid = valid_reg[idx_reg];
    assign key_match  = slot_key == key_reg;

    assign req_ready = state_reg == S_IDLE;
    assign ram_raddr = idx_reg;
    assign ram_waddr = idx_reg;
    assign ram_wdata = {val_reg, key_reg};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        res_valid  = 1'b0;
        res        = '0;
        ram_we     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next   = hash_home(req_key);
                    step_next  = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (slot_valid && !key_match && step_reg != LAST_STEP)
                begin
                    idx_next   = idx_reg + idx_t'(1);
                    step_next  = step_reg + idx_t'(1);
                    state_next = S_READ;
                end
                else if (res_free)
                begin
                    res_valid  = 1'b1;
                    res.slot   = idx_reg;
                    state_next = S_IDLE;
                    if (slot_valid && key_match)
                    begin
                        res.hit   = 1'b1;
                        res.value = slot_val;
                    end
                    else if (slot_valid)
                    begin
                        // probe wrapped all the way round: reported at home slot
                        res.full = 1'b1;
                        res.slot = idx_reg + idx_t'(1);
                    end
                    else if (count_reg >= HALF_DEPTH)
                    begin
                        res.full = 1'b1;
                    end
                    else
                    begin
                        res.value           = val_reg;
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        count_next          = count_reg + idx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        step_reg <= step_next;
        if (req_valid && req_ready)
        begin
            key_reg <= req_key;
            val_reg <= req_value;
        end
    end

endmodule

[rtl/fibonacci_hash_linear_probe_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibonacci_hash_linear_probe_table_top
// Lookup-or-insert hash table, linear probing from a Fibonacci-hashed home.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tdata = {insert_value, search_key}.
//   m_axis returns one result per request: tdata = {slot_index, found_value},
//   tuser = {table_full, hit}.
//   A request probes slots one at a time through the key/value RAM; each
//   probe is a RAM read (S_READ) followed by a compare (S_CHECK), and the
//   result shows on m_axis the cycle after the final compare.
//   A miss writes key and value into the empty slot during the final
//   compare; a refused miss (table at half load) writes nothing.
//   Reset clears the valid bits and entry count at once; no clearing pass.
//   If m_axis stalls, the finished result waits in the output register
//   while the next request is accepted and probed; that request then holds
//   in its final compare until the output register frees up.
// ----------------------------------------------------------------------------
module fibonacci_hash_linear_probe_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] search_key, [127:64] insert_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // [63:0] found_value, [71:64] slot_index
    output logic [1:0]   m_axis_tuser   // [0] hit, [1] table_full
);
    import fhlp_pkg::*;

    logic               res_free;
    logic               res_valid;
    result_t            res;
    idx_t               ram_raddr;
    idx_t               ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_we;

    logic               out_valid_reg;
    result_t            out_reg;
    logic [IDX_W+7:0]   slot_ext;

    fhlp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fhlp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_key   (s_axis_tdata[KEY_W-1:0]),
        .req_value (s_axis_tdata[ENTRY_W-1:KEY_W]),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    assign res_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    // slot index leaves the block masked to 8 bits
    assign slot_ext      = {8'd0, out_reg.slot};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {slot_ext[7:0], out_reg.value};
    assign m_axis_tuser  = {out_reg.full, out_reg.hit};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Fibonacci-hashed linear-probe table. A short
// table of requests covers empty-table inserts, hits, zero values, collision
// chains and wrap past the last slot. Random requests then mix repeat keys,
// fresh random keys and keys aimed at hot slots until the table passes half
// load and inserts are refused. Every result is checked in order against a
// behavioral copy of the table, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

    import fhlp_pkg::*;

    localparam int RANDOM_REQUESTS = 700;
    localparam int DIR_N           = 16;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
        idx_t             slot;
        logic             full;
    } lookup_result_t;

    typedef struct packed {
        logic             typed;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        lookup_result_t   result;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;    // [63:0] search_key, [127:64] insert_value
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;         // [63:0] found_value, [71:64] slot_index
    logic [1:0]   m_axis_tuser;         // [0] hit, [1] table_full

    // Behavioral copy of the table.
    logic             tbl_valid [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_key   [TABLE_DEPTH];
    logic [VAL_W-1:0] tbl_value [TABLE_DEPTH];
    int               tbl_count;

    lookup_result_t   pending_results[$];
    logic [KEY_W-1:0] stored_keys[$];
    int               error_count = 0;
    int               burst_left = 0;
    bit               no_idle = 1'b0;
    logic [15:0]      stall_pattern = '0;
    int unsigned      stall_phase = 0;

    // Typed rows: empty-table insert, hit, zero value, collision at slot 0,
    // first insert at the last slot.
    dir_row_t dir_rows [DIR_N] = '{
        '{1'b1, 64'h0, 64'h1111, '{1'b0, 64'h1111, 8'd0, 1'b0}},
        '{1'b1, 64'h0, 64'h2222, '{1'b1, 64'h1111, 8'd0, 1'b0}},
        '{1'b1, 64'h100, 64'h0, '{1'b0, 64'h0, 8'd1, 1'b0}},
        '{1'b1, 64'h100, 64'h5, '{1'b1, 64'h0, 8'd1, 1'b0}},
        '{1'b1, 64'hC3, 64'h33, '{1'b0, 64'h33, 8'd255, 1'b0}},
        '{1'b0, 64'h1C3, 64'h44, '0},
        '{1'b0, 64'h2C3, 64'h55, '0},
        '{1'b0, 64'h1C3, 64'h1, '0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, '0},
        '{1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0},
        '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0},
        '{1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0},
        '{1'b0, 64'h2C3, 64'h7, '0},
        '{1'b0, 64'h8000_0000_0000_0000, 64'h9, '0},
        '{1'b0, 64'hC3, 64'hFFFF_FFFF_FFFF_FFFF, '0}
    };

    fibonacci_hash_linear_probe_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #6ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Lookup-or-insert on the behavioral table.
    function automatic lookup_result_t table_access(input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] value);
        logic [63:0]    prod;
        idx_t           idx;
        bit             stop;
        lookup_result_t r;
        prod = key * HASH_MULT;
        idx  = prod[IDX_W-1:0];
        stop = 1'b0;
        for (int step = 0; step < TABLE_DEPTH && !stop; step++)
        begin
            if (!tbl_valid[idx] || tbl_key[idx] == key)
                stop = 1'b1;
            else
                idx = idx + 1'b1;
        end
        r      = '0;
        r.slot = idx;
        if (tbl_valid[idx] && tbl_key[idx] == key)
        begin
            r.hit   = 1'b1;
            r.value = tbl_value[idx];
        end
        else if (tbl_valid[idx] || (tbl_count + 1) * 2 > TABLE_DEPTH)
        begin
            r.full = 1'b1;
        end
        else
        begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx]   = key;
            tbl_value[idx] = value;
            tbl_count++;
            r.value = value;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // tvalid stays high between back-to-back requests.
    task automatic send_request(input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value,
                                input logic typed,
                                input lookup_result_t typed_result);
        lookup_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!no_idle && $urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {value, key};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = table_access(key, value);
        if (!predicted.hit && !predicted.full)
            stored_keys.insert(stored_keys.size(), key);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    // Receiver stalls follow a random ready pattern, redrawn each time the phase wraps.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
            stall_pattern = ($urandom_range(0, 7) == 0) ? 16'h0001
                                                        : (16'($urandom) | 16'h0101);
        m_axis_tready <= no_idle || stall_pattern[stall_phase];
        stall_phase = (stall_phase + 1) % 16;
    end

    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser[0] !== exp_r.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tdata[63:0] !== exp_r.value)
                begin
                    $error("found_value: expected %h, got %h", exp_r.value,
                           m_axis_tdata[63:0]);
                    error_count++;
                end
                if (m_axis_tdata[71:64] !== exp_r.slot)
                begin
                    $error("slot_index: expected %0d, got %0d", exp_r.slot,
                           m_axis_tdata[71:64]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== exp_r.full)
                begin
                    $error("table_full: expected %0d, got %0d", exp_r.full,
                           m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [7:0]       home;
        int               pick;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        tbl_count = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_request(dir_rows[i].key, dir_rows[i].value, dir_rows[i].typed,
                         dir_rows[i].result);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            no_idle = (n >= 300 && n < 380);
            pick = $urandom_range(0, 99);
            if (pick < 70 && stored_keys.size() > 0)
            begin
                // lookup of a stored key
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            end
            else if (pick < 85)
            begin
                key = {$urandom, $urandom};
            end
            else
            begin
                // aim at a hot slot near the wrap point: 61 inverts 0x15 mod 256,
                // so a low byte of home * 61 hashes to home
                home = 8'($urandom_range(0, 15) - 8);
                key  = {$urandom, $urandom};
                key[7:0] = 8'(home * 61);
            end
            case ($urandom_range(0, 15))
                0:       value = '0;
                1:       value = '1;
                default: value = {$urandom, $urandom};
            endcase
            send_request(key, value, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/fhlp_pkg.sv
rtl/fhlp_ram.sv
rtl/fhlp_engine.sv
rtl/fibonacci_hash_linear_probe_table_top.sv
tb/tb_top.sv
